// ===== rtl/i2cse_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cse_pkg
// Types and codes shared by the I2C status event sequencer files.
// ----------------------------------------------------------------------------
package i2cse_pkg;

	// Command codes
	localparam logic [1:0] CMD_BUS_EVENT = 2'd0;
	localparam logic [1:0] CMD_TX_WRITE  = 2'd1;
	localparam logic [1:0] CMD_RX_READ   = 2'd2;

	// Bus status event codes
	localparam logic [3:0] EV_START         = 4'd0;
	localparam logic [3:0] EV_SLAW_ACK      = 4'd1;
	localparam logic [3:0] EV_SLAW_NACK     = 4'd2;
	localparam logic [3:0] EV_DATA_TX_ACK   = 4'd3;
	localparam logic [3:0] EV_DATA_TX_NACK  = 4'd4;
	localparam logic [3:0] EV_SLAR_ACK      = 4'd5;
	localparam logic [3:0] EV_SLAR_NACK     = 4'd6;
	localparam logic [3:0] EV_DATA_RX_ACK   = 4'd7;
	localparam logic [3:0] EV_DATA_RX_NACK  = 4'd8;
	localparam logic [3:0] EV_OWN_ADDR_ACK  = 4'd9;
	localparam logic [3:0] EV_SLV_DATA_ACK  = 4'd10;
	localparam logic [3:0] EV_SLV_DATA_NACK = 4'd11;
	localparam logic [3:0] EV_STOP          = 4'd12;
	localparam logic [3:0] EV_BUS_ERROR     = 4'd13;

	// Error codes
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_SLAW_NACK  = 3'd1;
	localparam logic [2:0] ERR_DATA_NACK  = 3'd2;
	localparam logic [2:0] ERR_SLAR_NACK  = 3'd3;
	localparam logic [2:0] ERR_SLAVE_NACK = 3'd4;

	// Configuration register indexes
	localparam logic [2:0] REG_MODE     = 3'd0;
	localparam logic [2:0] REG_TARGET   = 3'd1;
	localparam logic [2:0] REG_TX_LEN   = 3'd2;
	localparam logic [2:0] REG_RX_LEN   = 3'd3;
	localparam logic [2:0] REG_OWN_ADDR = 3'd4;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 8;

	// Where the result byte comes from
	typedef enum logic [1:0] {
		SRC_CONST = 2'd0,
		SRC_TX    = 2'd1,
		SRC_RX    = 2'd2
	} drive_src_t;

	typedef struct packed {
		logic [1:0] command;
		logic [3:0] status_event;
		logic [7:0] bus_byte;
		logic [4:0] buffer_index;
		logic [7:0] buffer_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] drive_byte;
		logic       drive_valid;
		logic       request_stop;
		logic       request_ack;
		logic [2:0] error_code;
		logic       master_done;
		logic       slave_done;
		logic [5:0] received_count;
	} out_item_t;

	typedef struct packed {
		logic       mode_local_master;
		logic [6:0] target_address;
		logic [5:0] transmit_length;
		logic [5:0] receive_length;
		logic [7:0] own_address;
	} cfg_t;

	// Decoded request waiting for the message RAM read data
	typedef struct packed {
		drive_src_t src;
		logic [7:0] drive_byte;
		logic       drive_valid;
		logic       request_stop;
		logic       request_ack;
		logic [2:0] error_code;
		logic       master_done;
		logic       slave_done;
		logic [5:0] received_count;
	} stage_t;

endpackage

// ===== rtl/i2cse_ram.sv =====
// ----------------------------------------------------------------------------
// i2cse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module i2cse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/i2cse_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2cse_ctrl
// Event decoder with the transmit and receive byte counters. Drives the
// message RAM ports and produces the decoded request for the next stage.
// ----------------------------------------------------------------------------
module i2cse_ctrl import i2cse_pkg::*; #(
	parameter int MESSAGE_DEPTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  in_item_t                         item,
	input  cfg_t                             cfg,
	output stage_t                           stage,
	output logic                             tx_wr_en,
	output logic [$clog2(MESSAGE_DEPTH)-1:0] tx_wr_addr,
	output logic [7:0]                       tx_wr_data,
	output logic [$clog2(MESSAGE_DEPTH)-1:0] tx_rd_addr,
	output logic                             rx_wr_en,
	output logic [$clog2(MESSAGE_DEPTH)-1:0] rx_wr_addr,
	output logic [7:0]                       rx_wr_data,
	output logic [$clog2(MESSAGE_DEPTH)-1:0] rx_rd_addr
);

	localparam int AW   = $clog2(MESSAGE_DEPTH);
	localparam int CW   = $clog2(MESSAGE_DEPTH + 1);
	localparam int CMPW = (CW > 6) ? CW : 6;
	localparam int XW   = CMPW + 1;

	localparam logic [CW-1:0] DEPTH_C      = CW'(MESSAGE_DEPTH);
	localparam logic [CW-1:0] DEPTH_M1_C   = CW'(MESSAGE_DEPTH - 1);

	logic [CW-1:0] tx_count_q, tx_count_nxt;
	logic [CW-1:0] rx_count_q, rx_count_nxt;
	logic          idx_in_range;
	logic          tx_room, rx_room, rx_room_m1;
	logic          tx_wr, rx_wr;
	logic [XW-1:0] rx_len_m1;
	logic [XW-1:0] rx_count_inc;

	assign idx_in_range = int'(item.buffer_index) < MESSAGE_DEPTH;
	assign tx_room      = tx_count_q < DEPTH_C;
	assign rx_room      = rx_count_q < DEPTH_C;
	assign rx_room_m1   = rx_count_q < DEPTH_M1_C;
	assign rx_count_inc = XW'(rx_count_q) + XW'(1);
	assign rx_len_m1    = XW'(cfg.receive_length) - XW'(1);

	assign tx_wr_addr = AW'(item.buffer_index);
	assign tx_wr_data = item.buffer_byte;
	assign tx_rd_addr = tx_count_q[AW-1:0];
	assign rx_rd_addr = AW'(item.buffer_index);

	// Decode one request
	always_comb begin
		stage              = '0;
		stage.src          = SRC_CONST;
		tx_count_nxt       = tx_count_q;
		rx_count_nxt       = rx_count_q;
		tx_wr              = 1'b0;
		rx_wr              = 1'b0;
		rx_wr_addr         = rx_count_q[AW-1:0];
		rx_wr_data         = item.bus_byte;

		case (item.command)
			CMD_TX_WRITE: begin
				tx_wr = idx_in_range;
			end
			CMD_RX_READ: begin
				if (idx_in_range) begin
					stage.src = SRC_RX;
				end
			end
			CMD_BUS_EVENT: begin
				case (item.status_event)
					EV_START: begin
						rx_count_nxt      = '0;
						tx_count_nxt      = '0;
						stage.drive_byte  = {cfg.target_address, (cfg.transmit_length == 6'd0)};
						stage.drive_valid = 1'b1;
					end
					EV_SLAW_ACK, EV_DATA_TX_ACK: begin
						if (item.status_event == EV_DATA_TX_ACK &&
						    CMPW'(tx_count_q) == CMPW'(cfg.transmit_length)) begin
							stage.request_stop = 1'b1;
							stage.master_done  = 1'b1;
						end else begin
							stage.drive_valid = 1'b1;
							if (tx_room) begin
								stage.src    = SRC_TX;
								tx_count_nxt = tx_count_q + CW'(1);
							end
						end
					end
					EV_SLAW_NACK: begin
						stage.request_stop = 1'b1;
						stage.error_code   = ERR_SLAW_NACK;
						stage.master_done  = 1'b1;
					end
					EV_DATA_TX_NACK: begin
						stage.request_stop = 1'b1;
						stage.error_code   = ERR_DATA_NACK;
						stage.master_done  = 1'b1;
					end
					EV_SLAR_NACK: begin
						stage.request_stop = 1'b1;
						stage.error_code   = ERR_SLAR_NACK;
						stage.master_done  = 1'b1;
					end
					EV_SLAR_ACK: begin
						stage.request_ack = cfg.receive_length > 6'd1;
					end
					EV_DATA_RX_ACK: begin
						if (rx_room_m1) begin
							rx_wr             = 1'b1;
							rx_count_nxt      = rx_count_q + CW'(1);
							stage.request_ack = !(cfg.receive_length != 6'd0 &&
							                      rx_count_inc == rx_len_m1);
						end
					end
					EV_DATA_RX_NACK: begin
						if (rx_room) begin
							rx_wr        = 1'b1;
							rx_count_nxt = rx_count_q + CW'(1);
						end
						stage.request_stop = 1'b1;
						stage.master_done  = 1'b1;
					end
					EV_OWN_ADDR_ACK: begin
						rx_count_nxt = '0;
						rx_wr_addr   = '0;
						rx_wr_data   = cfg.own_address;
						if (!cfg.mode_local_master) begin
							rx_wr             = 1'b1;
							rx_count_nxt      = CW'(1);
							stage.request_ack = 1'b1;
						end
					end
					EV_SLV_DATA_ACK: begin
						if (rx_room) begin
							rx_wr             = 1'b1;
							rx_count_nxt      = rx_count_q + CW'(1);
							stage.request_ack = 1'b1;
						end
					end
					EV_SLV_DATA_NACK: begin
						stage.request_ack = 1'b1;
						stage.error_code  = ERR_SLAVE_NACK;
					end
					EV_STOP: begin
						stage.slave_done  = (cfg.mode_local_master && rx_count_q != '0) ||
						                    (!cfg.mode_local_master && rx_count_q > CW'(1));
						stage.request_ack = 1'b1;
					end
					EV_BUS_ERROR: begin
						stage.request_stop = 1'b1;
					end
					default: begin
					end
				endcase
				// A stop request always carries an acknowledge request
				if (stage.request_stop) begin
					stage.request_ack = 1'b1;
				end
			end
			default: begin
			end
		endcase

		stage.received_count = 6'(rx_count_nxt);
	end

	assign tx_wr_en = accept && tx_wr;
	assign rx_wr_en = accept && rx_wr;

	// Advance the byte counters on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_count_q <= '0;
			rx_count_q <= '0;
		end else if (accept) begin
			tx_count_q <= tx_count_nxt;
			rx_count_q <= rx_count_nxt;
		end
	end

endmodule

// ===== rtl/i2c_status_event_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_status_event_sequencer
// Answers one I2C bus status event, transmit store write or receive store
// read per request with the bus controller action for that request.
// ----------------------------------------------------------------------------
// One request is taken in every cycle while event_stall is low, and each request
// gives exactly one result: the decode stage presents the
// address to the transmit or receive message RAM, whose registered read port
// returns the byte in the following cycle; the result register loads it unless blocked.
// While a result waits on result_stall, the decode stage still takes one more
// request; after that event_stall stays high until the waiting result leaves.
// Configuration writes take effect at once and are meant for idle periods.
module i2c_status_event_sequencer import i2cse_pkg::*; #(
	parameter int MESSAGE_DEPTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   event_valid,
	output logic                   event_stall,
	input  in_item_t               event_item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output out_item_t              result_item
);

	localparam int AW = $clog2(MESSAGE_DEPTH);

	cfg_t      cfg_q;
	stage_t    stage_nxt;
	stage_t    stage_s1;
	logic      valid_s1;
	out_item_t result_q;
	logic      result_valid_q;
	out_item_t result_nxt;
	logic      advance;
	logic      accept;

	logic          tx_wr_en, rx_wr_en;
	logic [AW-1:0] tx_wr_addr, tx_rd_addr, rx_wr_addr, rx_rd_addr;
	logic [7:0]    tx_wr_data, rx_wr_data, tx_rd_data, rx_rd_data;

	assign advance     = !result_valid_q || !result_stall;
	assign event_stall = valid_s1 && !advance;
	assign accept      = event_valid && !event_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MODE:     cfg_q.mode_local_master <= cfg_data[0];
				REG_TARGET:   cfg_q.target_address    <= cfg_data[6:0];
				REG_TX_LEN:   cfg_q.transmit_length   <= cfg_data[5:0];
				REG_RX_LEN:   cfg_q.receive_length    <= cfg_data[5:0];
				REG_OWN_ADDR: cfg_q.own_address       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	i2cse_ctrl #(
		.MESSAGE_DEPTH(MESSAGE_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (event_item),
		.cfg        (cfg_q),
		.stage      (stage_nxt),
		.tx_wr_en   (tx_wr_en),
		.tx_wr_addr (tx_wr_addr),
		.tx_wr_data (tx_wr_data),
		.tx_rd_addr (tx_rd_addr),
		.rx_wr_en   (rx_wr_en),
		.rx_wr_addr (rx_wr_addr),
		.rx_wr_data (rx_wr_data),
		.rx_rd_addr (rx_rd_addr)
	);

	i2cse_ram #(
		.WIDTH(8),
		.DEPTH(MESSAGE_DEPTH)
	) u_tx_ram (
		.clk     (clk),
		.wr_en   (tx_wr_en),
		.wr_addr (tx_wr_addr),
		.wr_data (tx_wr_data),
		.rd_en   (accept),
		.rd_addr (tx_rd_addr),
		.rd_data (tx_rd_data)
	);

	i2cse_ram #(
		.WIDTH(8),
		.DEPTH(MESSAGE_DEPTH)
	) u_rx_ram (
		.clk     (clk),
		.wr_en   (rx_wr_en),
		.wr_addr (rx_wr_addr),
		.wr_data (rx_wr_data),
		.rd_en   (accept),
		.rd_addr (rx_rd_addr),
		.rd_data (rx_rd_data)
	);

	// Decode stage: hold while the result register is blocked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1 <= stage_nxt;
		end
	end

	// Merge the RAM read data into the result
	always_comb begin
		result_nxt.drive_valid    = stage_s1.drive_valid;
		result_nxt.request_stop   = stage_s1.request_stop;
		result_nxt.request_ack    = stage_s1.request_ack;
		result_nxt.error_code     = stage_s1.error_code;
		result_nxt.master_done    = stage_s1.master_done;
		result_nxt.slave_done     = stage_s1.slave_done;
		result_nxt.received_count = stage_s1.received_count;
		case (stage_s1.src)
			SRC_TX:  result_nxt.drive_byte = tx_rd_data;
			SRC_RX:  result_nxt.drive_byte = rx_rd_data;
			default: result_nxt.drive_byte = stage_s1.drive_byte;
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= result_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result_item  = result_q;

endmodule

// ===== rtl/i2cse_checker.sv =====
// ----------------------------------------------------------------------------
// i2cse_checker
// Port-level checks for the I2C status event sequencer, bound to the top.
// ----------------------------------------------------------------------------
module i2cse_checker import i2cse_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      event_stall,
	input logic      result_valid,
	input logic      result_stall,
	input out_item_t result_item
);

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_item))
		else $error("stalled result changed");

	// Stop always comes with acknowledge
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.request_stop |-> result_item.request_ack)
		else $error("stop without acknowledge");

	// Master address and data nacks end the master transfer with a stop
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_item.error_code == ERR_SLAW_NACK ||
		                 result_item.error_code == ERR_DATA_NACK ||
		                 result_item.error_code == ERR_SLAR_NACK)
		|-> result_item.master_done && result_item.request_stop)
		else $error("master error without done and stop");

	// Slave completion never drives the bus or stops it
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.slave_done
		|-> result_item.request_ack && !result_item.request_stop && !result_item.drive_valid)
		else $error("slave done with bus action");

	// With no result waiting, a request is never refused
	assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !event_stall)
		else $error("request stalled with empty output");

endmodule

bind i2c_status_event_sequencer i2cse_checker u_i2cse_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.event_stall  (event_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_item  (result_item)
);

// ===== verif/tb_i2c_status_event_sequencer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_status_event_sequencer
// Self-checking bench for the I2C status event sequencer. Requests are driven
// with random gaps and results are taken with random stalls. A behavioral
// model of the sequencer predicts each result as its request is accepted.
// Every result is compared field by field against the oldest prediction.
// Stimulus covers a directed pass over every event and command, then master
// write, master read and slave receive sequences, mixed traffic and noise,
// under many register settings.
// ----------------------------------------------------------------------------
module tb_i2c_status_event_sequencer;
	import i2cse_pkg::*;

	localparam int MSG_DEPTH = 32;

	// Event codes with no action and the ignored command code
	localparam logic [3:0] EV_OTHER_LO = 4'd14;
	localparam logic [3:0] EV_OTHER_HI = 4'd15;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   event_valid;
	logic                   event_stall;
	in_item_t               event_item;
	logic                   result_valid;
	logic                   result_stall;
	out_item_t              result_item;

	// Sequencer model state
	cfg_t        seq_cfg;
	logic [7:0]  tx_bytes [MSG_DEPTH];
	logic [7:0]  rx_bytes [MSG_DEPTH];
	logic [31:0] rx_filled;
	int          tx_count;
	int          rx_count;

	out_item_t   pending_results [$];
	int          fail_count;
	int          requests_sent;
	bit          idle_on;

	i2c_status_event_sequencer #(
		.MESSAGE_DEPTH(MSG_DEPTH)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.event_item  (event_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item (result_item)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Compute the result of one request and advance the model state
	function automatic out_item_t sequence_event(input in_item_t req);
		out_item_t res;
		res = '0;
		case (req.command)
			CMD_TX_WRITE: tx_bytes[req.buffer_index] = req.buffer_byte;
			CMD_RX_READ: res.drive_byte = rx_bytes[req.buffer_index];
			CMD_BUS_EVENT: begin
				case (req.status_event)
					EV_START: begin
						rx_count = 0;
						tx_count = 0;
						res.drive_byte = {seq_cfg.target_address, seq_cfg.transmit_length == 6'd0};
						res.drive_valid = 1'b1;
					end
					EV_SLAW_ACK, EV_DATA_TX_ACK: begin
						if (req.status_event == EV_DATA_TX_ACK &&
						    tx_count == int'(seq_cfg.transmit_length)) begin
							res.request_stop = 1'b1;
							res.master_done = 1'b1;
						end else begin
							res.drive_valid = 1'b1;
							if (tx_count < MSG_DEPTH) begin
								res.drive_byte = tx_bytes[tx_count];
								tx_count++;
							end
						end
					end
					EV_SLAW_NACK: begin
						res.request_stop = 1'b1;
						res.error_code = ERR_SLAW_NACK;
						res.master_done = 1'b1;
					end
					EV_DATA_TX_NACK: begin
						res.request_stop = 1'b1;
						res.error_code = ERR_DATA_NACK;
						res.master_done = 1'b1;
					end
					EV_SLAR_NACK: begin
						res.request_stop = 1'b1;
						res.error_code = ERR_SLAR_NACK;
						res.master_done = 1'b1;
					end
					EV_SLAR_ACK: res.request_ack = seq_cfg.receive_length > 6'd1;
					EV_DATA_RX_ACK: begin
						// drop the byte once the store is nearly full
						if (rx_count < MSG_DEPTH - 1) begin
							rx_bytes[rx_count] = req.bus_byte;
							rx_filled[rx_count] = 1'b1;
							rx_count++;
							res.request_ack = !(seq_cfg.receive_length != 6'd0 &&
								rx_count == int'(seq_cfg.receive_length) - 1);
						end
					end
					EV_DATA_RX_NACK: begin
						if (rx_count < MSG_DEPTH) begin
							rx_bytes[rx_count] = req.bus_byte;
							rx_filled[rx_count] = 1'b1;
							rx_count++;
						end
						res.request_stop = 1'b1;
						res.master_done = 1'b1;
					end
					EV_OWN_ADDR_ACK: begin
						rx_count = 0;
						// keep the own address as the first message byte
						if (!seq_cfg.mode_local_master) begin
							rx_bytes[0] = seq_cfg.own_address;
							rx_filled[0] = 1'b1;
							rx_count = 1;
							res.request_ack = 1'b1;
						end
					end
					EV_SLV_DATA_ACK: begin
						if (rx_count < MSG_DEPTH) begin
							rx_bytes[rx_count] = req.bus_byte;
							rx_filled[rx_count] = 1'b1;
							rx_count++;
							res.request_ack = 1'b1;
						end
					end
					EV_SLV_DATA_NACK: begin
						res.request_ack = 1'b1;
						res.error_code = ERR_SLAVE_NACK;
					end
					EV_STOP: begin
						res.slave_done = (seq_cfg.mode_local_master && rx_count > 0) ||
							(!seq_cfg.mode_local_master && rx_count > 1);
						res.request_ack = 1'b1;
					end
					EV_BUS_ERROR: res.request_stop = 1'b1;
					default: ;
				endcase
				if (res.request_stop)
					res.request_ack = 1'b1;
			end
			default: ;
		endcase
		res.received_count = 6'(rx_count);
		return res;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Predict on each accepted request, check each accepted result
	always @(posedge clk) begin
		out_item_t want;
		if (result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("drive_byte", int'(want.drive_byte),
					int'(result_item.drive_byte));
				check_field("drive_valid", int'(want.drive_valid),
					int'(result_item.drive_valid));
				check_field("request_stop", int'(want.request_stop),
					int'(result_item.request_stop));
				check_field("request_ack", int'(want.request_ack),
					int'(result_item.request_ack));
				check_field("error_code", int'(want.error_code),
					int'(result_item.error_code));
				check_field("master_done", int'(want.master_done),
					int'(result_item.master_done));
				check_field("slave_done", int'(want.slave_done),
					int'(result_item.slave_done));
				check_field("received_count", int'(want.received_count),
					int'(result_item.received_count));
			end
		end
		if (event_valid && !event_stall)
			pending_results.push_back(sequence_event(event_item));
	end

	// Stall the result side in random bursts
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				result_stall = 1'b1;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				result_stall = 1'b0;
			end
		end
	end

	// Drive one request and hold it until accepted; returns at a falling edge
	task automatic send_request(input in_item_t req);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			event_valid = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		event_valid = 1'b1;
		event_item = req;
		do @(posedge clk); while (event_stall);
		@(negedge clk);
		event_valid = 1'b0;
		requests_sent++;
	endtask

	function automatic in_item_t random_item();
		in_item_t r;
		r.command = 2'($urandom_range(0, 3));
		r.status_event = 4'($urandom_range(0, 15));
		r.bus_byte = 8'($urandom_range(0, 255));
		r.buffer_index = 5'($urandom_range(0, MSG_DEPTH - 1));
		r.buffer_byte = 8'($urandom_range(0, 255));
		return r;
	endfunction

	function automatic int pick_filled_index();
		int idx;
		if (rx_filled == '0)
			return -1;
		idx = $urandom_range(0, MSG_DEPTH - 1);
		while (!rx_filled[idx])
			idx = (idx + 1) % MSG_DEPTH;
		return idx;
	endfunction

	// Point a receive read at an entry already written, else turn it into a write
	function automatic in_item_t legal_read(input in_item_t r);
		int idx;
		idx = pick_filled_index();
		if (idx < 0)
			r.command = CMD_TX_WRITE;
		else
			r.buffer_index = 5'(idx);
		return r;
	endfunction

	task automatic send_event(input logic [3:0] ev);
		in_item_t r;
		r = random_item();
		r.command = CMD_BUS_EVENT;
		r.status_event = ev;
		send_request(r);
	endtask

	task automatic send_store(input logic [1:0] cmd, input int idx, input int value);
		in_item_t r;
		r = random_item();
		r.command = cmd;
		r.buffer_index = 5'(idx);
		r.buffer_byte = 8'(value);
		send_request(r);
	endtask

	// Wait until every result has come back, plus the pipeline depth
	task automatic drain();
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = CFG_DATA_W'(value);
		case (idx)
			REG_MODE:     seq_cfg.mode_local_master = 1'(value);
			REG_TARGET:   seq_cfg.target_address = 7'(value);
			REG_TX_LEN:   seq_cfg.transmit_length = 6'(value);
			REG_RX_LEN:   seq_cfg.receive_length = 6'(value);
			REG_OWN_ADDR: seq_cfg.own_address = 8'(value);
			default: ;
		endcase
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	task automatic apply_config(input int mode, input int target, input int tx_len,
		input int rx_len, input int own);
		drain();
		write_reg(REG_MODE, mode);
		write_reg(REG_TARGET, target);
		write_reg(REG_TX_LEN, tx_len);
		write_reg(REG_RX_LEN, rx_len);
		write_reg(REG_OWN_ADDR, own);
	endtask

	// Pick a low, high or in-between value
	function automatic int pick_value(input int lo, input int hi, input int mid_hi);
		case ($urandom_range(0, 5))
			0: return lo;
			1: return hi;
			default: return $urandom_range(lo, mid_hi);
		endcase
	endfunction

	task automatic random_config();
		apply_config($urandom_range(0, 1), pick_value(0, 127, 127),
			pick_value(0, MSG_DEPTH, 8), pick_value(0, MSG_DEPTH, 8),
			pick_value(0, 255, 255));
	endtask

	task automatic do_master_write();
		int steps;
		bit last;
		send_event(EV_START);
		if ($urandom_range(0, 9) == 0) begin
			send_event(EV_SLAW_NACK);
			return;
		end
		send_event(EV_SLAW_ACK);
		steps = 0;
		last = 1'b0;
		while (!last && steps < 36) begin
			if ($urandom_range(0, 19) == 0) begin
				send_event(EV_DATA_TX_NACK);
				if ($urandom_range(0, 1))
					send_event(EV_SLAR_ACK);
				return;
			end
			last = tx_count == int'(seq_cfg.transmit_length);
			send_event(EV_DATA_TX_ACK);
			steps++;
		end
	endtask

	task automatic do_master_read();
		int n;
		send_event(EV_START);
		if ($urandom_range(0, 9) == 0) begin
			send_event(EV_SLAR_NACK);
			return;
		end
		send_event(EV_SLAR_ACK);
		if (seq_cfg.receive_length == 6'd0 || $urandom_range(0, 7) == 0)
			n = $urandom_range(0, 34);
		else
			n = int'(seq_cfg.receive_length) - 1;
		repeat (n) send_event(EV_DATA_RX_ACK);
		send_event(EV_DATA_RX_NACK);
		// push past the end of the store
		if (rx_count >= MSG_DEPTH - 1)
			repeat (2) send_event(EV_DATA_RX_NACK);
	endtask

	task automatic do_slave_receive();
		int n;
		send_event(EV_OWN_ADDR_ACK);
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 34) : $urandom_range(0, 4);
		repeat (n) begin
			if ($urandom_range(0, 11) == 0)
				send_event(EV_SLV_DATA_NACK);
			else
				send_event(EV_SLV_DATA_ACK);
		end
		send_event(EV_STOP);
	endtask

	task automatic do_store_access();
		in_item_t r;
		r = random_item();
		r.command = $urandom_range(0, 1) ? CMD_TX_WRITE : CMD_RX_READ;
		if (r.command == CMD_RX_READ)
			r = legal_read(r);
		send_request(r);
	endtask

	task automatic do_noise();
		in_item_t r;
		r = random_item();
		if (r.command == CMD_RX_READ)
			r = legal_read(r);
		send_request(r);
	endtask

	// Fill the whole transmit store so that every transmit event reads written data
	task automatic test_transmit_fill();
		apply_config(0, 0, 0, 0, 0);
		for (int i = 0; i < MSG_DEPTH; i++)
			send_store(CMD_TX_WRITE, i, $urandom_range(0, 255));
	endtask

	// Walk every event, every command and the field extremes once
	task automatic test_each_event();
		apply_config(0, 127, 2, 3, 255);
		send_store(CMD_TX_WRITE, MSG_DEPTH - 1, 255);
		send_store(CMD_TX_WRITE, 0, 0);
		send_event(EV_START);
		send_event(EV_SLAW_ACK);
		send_event(EV_DATA_TX_ACK);
		send_event(EV_DATA_TX_ACK);
		send_event(EV_SLAW_NACK);
		send_event(EV_DATA_TX_NACK);
		send_event(EV_START);
		send_event(EV_SLAR_ACK);
		send_event(EV_DATA_RX_ACK);
		send_event(EV_DATA_RX_ACK);
		send_event(EV_DATA_RX_NACK);
		send_event(EV_SLAR_NACK);
		send_event(EV_OWN_ADDR_ACK);
		send_event(EV_SLV_DATA_ACK);
		send_event(EV_SLV_DATA_NACK);
		send_event(EV_STOP);
		send_event(EV_BUS_ERROR);
		send_event(EV_OTHER_LO);
		send_event(EV_OTHER_HI);
		send_store(CMD_UNUSED, MSG_DEPTH - 1, 255);
		send_store(CMD_RX_READ, 0, 0);
		send_store(CMD_RX_READ, 1, 0);
	endtask

	task automatic test_master_write(input int n_items);
		int stop_at;
		stop_at = requests_sent + n_items;
		while (requests_sent < stop_at) begin
			random_config();
			repeat (4) do_master_write();
		end
	endtask

	task automatic test_master_read(input int n_items);
		int stop_at;
		stop_at = requests_sent + n_items;
		while (requests_sent < stop_at) begin
			random_config();
			repeat (4) begin
				do_master_read();
				do_store_access();
			end
		end
	endtask

	task automatic test_slave_receive(input int n_items);
		int stop_at;
		stop_at = requests_sent + n_items;
		while (requests_sent < stop_at) begin
			random_config();
			repeat (6) begin
				do_slave_receive();
				do_store_access();
			end
		end
	endtask

	task automatic test_mixed_traffic(input int n_items, input bit with_idle);
		int stop_at;
		stop_at = requests_sent + n_items;
		while (requests_sent < stop_at) begin
			random_config();
			idle_on = with_idle;
			repeat (8) begin
				case ($urandom_range(0, 9))
					0, 1, 2: do_master_write();
					3, 4:    do_master_read();
					5, 6:    do_slave_receive();
					7:       do_store_access();
					default: do_noise();
				endcase
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		event_valid = 1'b0;
		event_item = '0;
		seq_cfg = '0;
		tx_count = 0;
		rx_count = 0;
		rx_filled = '0;
		fail_count = 0;
		requests_sent = 0;
		idle_on = 1'b1;
		foreach (tx_bytes[i]) begin
			tx_bytes[i] = '0;
			rx_bytes[i] = '0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_transmit_fill();
		test_each_event();
		test_master_write(200);
		test_master_read(200);
		test_slave_receive(200);
		test_mixed_traffic(200, 1'b1);
		test_mixed_traffic(120, 1'b0);

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Bound the run
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
